### sv/bdrb_pkg.sv
// Shared types and constants for the bounded deque ring buffer.
package bdrb_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;

  localparam int KIND_W   = 3;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 8;
  localparam int ENT_W    = 9;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 112;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_BACK   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_READ_AT    = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

### sv/bounded_deque_ring_buffer.sv
// Bounded deque ring buffer: input register, core and storage RAM.
// A request is held in the input register, then in the result register that drives tvalid; output stalls hold it.
// Throughput: one request per cycle unless the output stalls; the storage RAM has one write
// and one read port and the end words are cached, so every request needs at most one RAM read.
// Reset: asynchronous, active low; the queue is empty after reset.
// Storage contents are not cleared; only written entries are ever read.
module bounded_deque_ring_buffer #(
  parameter int CAPACITY   = bdrb_pkg::CAPACITY,
  parameter int DATA_WIDTH = bdrb_pkg::DATA_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // value[31:0], position[39:32]
  input  logic [bdrb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind[2:0]
  input  logic [bdrb_pkg::KIND_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // data[31:0], front_word[63:32], back_word[95:64], entries[104:96],
  // is_empty[105], zero fill[111:106]
  output logic [bdrb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status[1:0]
  output logic [bdrb_pkg::STATUS_W-1:0]      m_axis_tuser
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int OW = bdrb_pkg::WORD_W;
  localparam int EW = bdrb_pkg::ENT_W;
  localparam int FW = bdrb_pkg::OUT_DATA_W - 3 * OW - EW - 1;

  logic                               in_v_q, out_v_q;
  bdrb_pkg::kind_e                    kind_q;
  logic signed [OW-1:0]               value_q;
  logic [bdrb_pkg::POS_W-1:0]         pos_q;
  logic                               s_xfer, adv;

  bdrb_pkg::mem_ctl_t                 mem;
  logic [PW-1:0]                      waddr, raddr;
  logic [DATA_WIDTH-1:0]              wdata, rdata;
  logic [DATA_WIDTH-1:0]              data_w, front_w, back_w;
  logic [CW-1:0]                      count;
  bdrb_pkg::status_e                  status;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_xfer) begin
        in_v_q <= 1'b1;
      end else if (adv) begin
        in_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      kind_q  <= bdrb_pkg::kind_e'(s_axis_tuser);
      value_q <= s_axis_tdata[OW-1:0];
      pos_q   <= s_axis_tdata[OW +: bdrb_pkg::POS_W];
    end
  end

  bdrb_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .kind_i   (kind_q),
    .value_i  (value_q),
    .pos_i    (pos_q),
    .rd_i     (rdata),
    .mem_o    (mem),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .raddr_o  (raddr),
    .data_o   (data_w),
    .front_o  (front_w),
    .back_o   (back_w),
    .count_o  (count),
    .status_o (status)
  );

  bdrb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem.we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (mem.re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {
    FW'(0),
    (count == '0),
    EW'(count),
    OW'(back_w),
    OW'(front_w),
    OW'(data_w)
  };
  assign m_axis_tuser  = status;

endmodule

### sv/bdrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bdrb_core.sv
// Pointer, count and end-word cache logic with the result register.
module bdrb_core #(
  parameter int CAPACITY   = bdrb_pkg::CAPACITY,
  parameter int DATA_WIDTH = bdrb_pkg::DATA_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  bdrb_pkg::kind_e                    kind_i,
  input  logic signed [bdrb_pkg::WORD_W-1:0] value_i,
  input  logic [bdrb_pkg::POS_W-1:0]         pos_i,
  input  logic [DATA_WIDTH-1:0]              rd_i,
  output bdrb_pkg::mem_ctl_t                 mem_o,
  output logic [$clog2(CAPACITY)-1:0]        waddr_o,
  output logic [DATA_WIDTH-1:0]              wdata_o,
  output logic [$clog2(CAPACITY)-1:0]        raddr_o,
  output logic [DATA_WIDTH-1:0]              data_o,
  output logic [DATA_WIDTH-1:0]              front_o,
  output logic [DATA_WIDTH-1:0]              back_o,
  output logic [$clog2(CAPACITY+1)-1:0]      count_o,
  output bdrb_pkg::status_e                  status_o
);

  localparam int PW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int DW  = DATA_WIDTH;
  localparam int SW  = ((PW > bdrb_pkg::POS_W) ? PW : bdrb_pkg::POS_W) + 1;
  localparam int KW  = (CW > bdrb_pkg::POS_W) ? CW : bdrb_pkg::POS_W;
  localparam logic [PW-1:0] LAST = PW'(CAPACITY - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? LAST : p - 1'b1;
  endfunction

  logic [PW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]      count_q, count_d;
  logic [DW-1:0]      front_q, front_d, back_q, back_d, data_q, data_d;
  logic               front_mem_q, front_mem_d, back_mem_q, back_mem_d;
  logic               data_mem_q, data_mem_d;
  bdrb_pkg::status_e  status_q, status_d;

  logic [DW-1:0] fc, bc, word;
  logic          full, empty, one;
  logic [SW-1:0] sum, sum_w;
  logic          we_c, re_c;

  assign fc    = front_mem_q ? rd_i : front_q;
  assign bc    = back_mem_q ? rd_i : back_q;
  assign word  = DW'($unsigned(value_i));
  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);
  assign one   = (count_q == CW'(1));
  assign sum   = SW'(head_q) + SW'(pos_i);
  assign sum_w = (sum >= SW'(CAPACITY)) ? sum - SW'(CAPACITY) : sum;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    front_d     = fc;
    back_d      = bc;
    front_mem_d = 1'b0;
    back_mem_d  = 1'b0;
    data_d      = '0;
    data_mem_d  = 1'b0;
    status_d    = bdrb_pkg::ST_OK;
    we_c        = 1'b0;
    re_c        = 1'b0;
    waddr_o     = tail_q;
    raddr_o     = head_q;
    case (kind_i)
      bdrb_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          status_d = bdrb_pkg::ST_FULL;
        end else begin
          we_c    = 1'b1;
          waddr_o = tail_q;
          tail_d  = ptr_inc(tail_q);
          count_d = count_q + 1'b1;
          back_d  = word;
          if (empty) begin
            front_d = word;
          end
        end
      end
      bdrb_pkg::KIND_PUSH_FRONT: begin
        if (full) begin
          status_d = bdrb_pkg::ST_FULL;
        end else begin
          we_c    = 1'b1;
          head_d  = ptr_dec(head_q);
          waddr_o = head_d;
          count_d = count_q + 1'b1;
          front_d = word;
          if (empty) begin
            back_d = word;
          end
        end
      end
      bdrb_pkg::KIND_POP_BACK: begin
        if (empty) begin
          status_d = bdrb_pkg::ST_EMPTY;
        end else begin
          tail_d  = ptr_dec(tail_q);
          count_d = count_q - 1'b1;
          data_d  = bc;
          if (!one) begin
            re_c       = 1'b1;
            raddr_o    = ptr_dec(tail_d);
            back_mem_d = 1'b1;
          end
        end
      end
      bdrb_pkg::KIND_POP_FRONT: begin
        if (empty) begin
          status_d = bdrb_pkg::ST_EMPTY;
        end else begin
          head_d  = ptr_inc(head_q);
          count_d = count_q - 1'b1;
          data_d  = fc;
          if (!one) begin
            re_c        = 1'b1;
            raddr_o     = head_d;
            front_mem_d = 1'b1;
          end
        end
      end
      bdrb_pkg::KIND_READ_AT: begin
        if (KW'(pos_i) >= KW'(count_q)) begin
          status_d = bdrb_pkg::ST_RANGE;
        end else begin
          re_c       = 1'b1;
          raddr_o    = sum_w[PW-1:0];
          data_mem_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_o.we = adv_i && we_c;
  assign mem_o.re = adv_i && re_c;
  assign wdata_o  = word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      front_mem_q <= 1'b0;
      back_mem_q  <= 1'b0;
      data_mem_q  <= 1'b0;
      status_q    <= bdrb_pkg::ST_OK;
    end else if (adv_i) begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      front_mem_q <= front_mem_d;
      back_mem_q  <= back_mem_d;
      data_mem_q  <= data_mem_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      front_q <= front_d;
      back_q  <= back_d;
      data_q  <= data_d;
    end
  end

  assign data_o   = data_mem_q ? rd_i : data_q;
  assign front_o  = (count_q == '0) ? '0 : fc;
  assign back_o   = (count_q == '0) ? '0 : bc;
  assign count_o  = count_q;
  assign status_o = status_q;

endmodule

### verif/bounded_deque_ring_buffer_tb.sv
// Self-checking testbench for the bounded deque ring buffer: directed and random requests.
`timescale 1ns / 1ps

module bounded_deque_ring_buffer_tb;

  typedef logic [bdrb_pkg::KIND_W-1:0] kind_t;
  typedef logic [bdrb_pkg::WORD_W-1:0] word_t;
  typedef logic [bdrb_pkg::POS_W-1:0]  pos_t;

  localparam kind_t KIND_SPARE_FIRST = 3'd5;
  localparam kind_t KIND_SPARE_LAST  = 3'd7;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 45;

  typedef struct packed {
    logic [bdrb_pkg::WORD_W-1:0] data;
    logic [bdrb_pkg::WORD_W-1:0] front_word;
    logic [bdrb_pkg::WORD_W-1:0] back_word;
    logic [bdrb_pkg::ENT_W-1:0]  entries;
    logic                        is_empty;
    bdrb_pkg::status_e           status;
  } deque_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [bdrb_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [bdrb_pkg::KIND_W-1:0]     s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bdrb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [bdrb_pkg::STATUS_W-1:0]   m_axis_tuser;

  // shadow deque
  word_t ring_words [bdrb_pkg::CAPACITY];
  int head_idx = 0;
  int tail_idx = 0;
  int fill_count = 0;

  deque_result_t pending_results [$];
  deque_result_t due_result;
  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;

  bounded_deque_ring_buffer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic predict_request(input kind_t kind, input word_t value, input pos_t pos);
    deque_result_t r;
    r = '0;
    r.status = bdrb_pkg::ST_OK;
    case (kind)
      bdrb_pkg::KIND_PUSH_BACK: begin
        if (fill_count == bdrb_pkg::CAPACITY) begin
          r.status = bdrb_pkg::ST_FULL;
        end else begin
          ring_words[tail_idx] = value;
          tail_idx = (tail_idx + 1) % bdrb_pkg::CAPACITY;
          fill_count++;
        end
      end
      bdrb_pkg::KIND_PUSH_FRONT: begin
        if (fill_count == bdrb_pkg::CAPACITY) begin
          r.status = bdrb_pkg::ST_FULL;
        end else begin
          head_idx = (head_idx + bdrb_pkg::CAPACITY - 1) % bdrb_pkg::CAPACITY;
          ring_words[head_idx] = value;
          fill_count++;
        end
      end
      bdrb_pkg::KIND_POP_BACK: begin
        if (fill_count == 0) begin
          r.status = bdrb_pkg::ST_EMPTY;
        end else begin
          tail_idx = (tail_idx + bdrb_pkg::CAPACITY - 1) % bdrb_pkg::CAPACITY;
          r.data = ring_words[tail_idx];
          fill_count--;
        end
      end
      bdrb_pkg::KIND_POP_FRONT: begin
        if (fill_count == 0) begin
          r.status = bdrb_pkg::ST_EMPTY;
        end else begin
          r.data = ring_words[head_idx];
          head_idx = (head_idx + 1) % bdrb_pkg::CAPACITY;
          fill_count--;
        end
      end
      bdrb_pkg::KIND_READ_AT: begin
        if (int'(pos) >= fill_count) begin
          r.status = bdrb_pkg::ST_RANGE;
        end else begin
          r.data = ring_words[(head_idx + int'(pos)) % bdrb_pkg::CAPACITY];
        end
      end
      default: ;
    endcase
    if (fill_count != 0) begin
      r.front_word = ring_words[head_idx];
      r.back_word  = ring_words[(tail_idx + bdrb_pkg::CAPACITY - 1) % bdrb_pkg::CAPACITY];
    end
    r.entries  = fill_count[bdrb_pkg::ENT_W-1:0];
    r.is_empty = (fill_count == 0);
    pending_results = {pending_results, r};
  endtask

  // Entered from a rising edge; returns at the edge of the transfer.
  task automatic send_request(input kind_t kind, input word_t value, input pos_t pos);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, value};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(kind, value, pos);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string label, input word_t want, input word_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h / %h", $time,
                 m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        due_result = pending_results[0];
        pending_results.delete(0);
        check_field("data", due_result.data, m_axis_tdata[31:0]);
        check_field("front_word", due_result.front_word, m_axis_tdata[63:32]);
        check_field("back_word", due_result.back_word, m_axis_tdata[95:64]);
        check_field("entries", 32'(due_result.entries), 32'(m_axis_tdata[104:96]));
        check_field("is_empty", 32'(due_result.is_empty), 32'(m_axis_tdata[105]));
        check_field("zero fill", '0, 32'(m_axis_tdata[111:106]));
        check_field("status", 32'(due_result.status), 32'(m_axis_tuser));
      end
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_requests();
    send_request(bdrb_pkg::KIND_POP_BACK, 32'hFFFF_FFFF, 8'hFF);
    send_request(bdrb_pkg::KIND_POP_FRONT, 32'h0, 8'h0);
    send_request(bdrb_pkg::KIND_READ_AT, 32'h0, 8'h0);
    send_request(bdrb_pkg::KIND_READ_AT, 32'h0, 8'hFF);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_request(k[bdrb_pkg::KIND_W-1:0], 32'hA5A5_5A5A, 8'h5A);
    end
    wait_drained();
  endtask

  task automatic test_end_values();
    send_request(bdrb_pkg::KIND_PUSH_BACK, 32'h7FFF_FFFF, 8'h00);
    send_request(bdrb_pkg::KIND_PUSH_FRONT, 32'h8000_0000, 8'hFF);
    send_request(bdrb_pkg::KIND_PUSH_BACK, 32'h0000_0000, 8'h00);
    send_request(bdrb_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF, 8'h00);
    for (int p = 0; p < 5; p++) begin
      send_request(bdrb_pkg::KIND_READ_AT, 32'h0, p[bdrb_pkg::POS_W-1:0]);
    end
    send_request(bdrb_pkg::KIND_READ_AT, 32'h0, 8'hFF);
    send_request(KIND_SPARE_LAST, 32'h1234_5678, 8'h01);
    send_request(bdrb_pkg::KIND_POP_FRONT, 32'h0, 8'h0);
    send_request(bdrb_pkg::KIND_POP_BACK, 32'h0, 8'h0);
    send_request(bdrb_pkg::KIND_POP_BACK, 32'h0, 8'h0);
    send_request(bdrb_pkg::KIND_POP_FRONT, 32'h0, 8'h0);
    send_request(bdrb_pkg::KIND_POP_FRONT, 32'h0, 8'h0);
    send_request(bdrb_pkg::KIND_POP_BACK, 32'h0, 8'h0);
    wait_drained();
  endtask

  task automatic test_full_queue();
    for (int n = 0; n < bdrb_pkg::CAPACITY; n++) begin
      send_request($urandom_range(1) ? bdrb_pkg::KIND_PUSH_FRONT : bdrb_pkg::KIND_PUSH_BACK,
                   pick_word(), 8'h0);
    end
    send_request(bdrb_pkg::KIND_PUSH_BACK, 32'h1111_1111, 8'h0);
    send_request(bdrb_pkg::KIND_PUSH_FRONT, 32'h2222_2222, 8'h0);
    send_request(bdrb_pkg::KIND_READ_AT, 32'h0, 8'hFF);
    send_request(bdrb_pkg::KIND_READ_AT, 32'h0, 8'h00);
    send_request(KIND_SPARE_FIRST, 32'h0, 8'h0);
    for (int n = 0; n < bdrb_pkg::CAPACITY; n++) begin
      send_request($urandom_range(1) ? bdrb_pkg::KIND_POP_FRONT : bdrb_pkg::KIND_POP_BACK,
                   32'h0, 8'h0);
    end
    send_request(bdrb_pkg::KIND_POP_FRONT, 32'h0, 8'h0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        @(posedge clk_i);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 40; n++) begin
        send_request($urandom_range(3) == 0 ? bdrb_pkg::KIND_READ_AT : bdrb_pkg::KIND_PUSH_BACK,
                     pick_word(), pos_t'($urandom_range(fill_count)));
      end
    join
    wait_drained();
  endtask

  task automatic test_random_phase(input int items, input int idle_pct, input int stall_pct);
    kind_t kind;
    pos_t  pos;
    int lean;
    int roll;
    int push_pct;
    lean = 1;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) begin
      if (n % 48 == 0) lean = $urandom_range(2);
      roll = $urandom_range(99);
      if (roll < 5) begin
        kind = kind_t'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
      end else if (roll < 20) begin
        kind = bdrb_pkg::KIND_READ_AT;
      end else begin
        push_pct = (lean == 2) ? 85 : (lean == 1) ? 50 : 15;
        if ($urandom_range(99) < push_pct) begin
          kind = $urandom_range(1) ? bdrb_pkg::KIND_PUSH_FRONT : bdrb_pkg::KIND_PUSH_BACK;
        end else begin
          kind = $urandom_range(1) ? bdrb_pkg::KIND_POP_FRONT : bdrb_pkg::KIND_POP_BACK;
        end
      end
      if (fill_count > 0 && $urandom_range(9) < 8) begin
        pos = pos_t'($urandom_range(fill_count - 1));
      end else begin
        pos = pos_t'($urandom_range(255));
      end
      send_request(kind, pick_word(), pos);
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_requests();
    test_end_values();
    test_full_queue();
    test_backpressure();
    test_random_phase(RANDOM_ITEMS, 0, 0);
    test_random_phase(RANDOM_ITEMS, 62, 0);
    test_random_phase(RANDOM_ITEMS, 0, 62);
    test_random_phase(RANDOM_ITEMS, 25, 25);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

endmodule
